@@ rtl/d2q5lbm_pkg.sv @@
// Shared widths, constants and stage payload types of the D2Q5 collision unit.
// No dependencies; used by every module under rtl.
package d2q5lbm_pkg;

  localparam int DW         = 32;  // distribution / density width, signed
  localparam int C2_W       = 16;  // squared sound speed, unsigned Q0.16
  localparam int OMEGA_W    = 18;  // relaxation rate, unsigned Q2.16
  localparam int C2_FRAC    = 16;
  localparam int OMEGA_FRAC = 16;

  localparam int RHO_W = DW + 3;            // sum of five distributions
  localparam int J_W   = DW + 1;            // difference of two distributions
  localparam int K0_W  = C2_W + 2;          // 1 - 2*c2, signed
  localparam int WS_W  = OMEGA_W + 1;       // omega and 1 - omega, signed
  localparam int P0_W  = RHO_W + K0_W;      // rho * (1 - 2*c2)
  localparam int CR_W  = RHO_W + C2_W + 1;  // c2 * rho
  localparam int EQS_W = CR_W + 1;          // c2*rho + d.J shifted, plus rounding
  localparam int FEQ_W = RHO_W + 1;         // rounded equilibrium
  localparam int RA_W  = WS_W + DW;         // (1 - omega) * f
  localparam int RB_W  = WS_W + FEQ_W;      // omega * feq
  localparam int ACC_W = RB_W + 1;
  localparam int SH_W  = ACC_W - OMEGA_FRAC;

  localparam int NDIR       = 5;
  localparam int DIR_REST   = 0;
  localparam int DIR_EAST   = 1;
  localparam int DIR_NORTH  = 2;
  localparam int DIR_WEST   = 3;
  localparam int DIR_SOUTH  = 4;

  localparam logic [OMEGA_W-1:0] RELAX_RESET = OMEGA_W'(2 << OMEGA_FRAC);
  localparam logic [OMEGA_W-1:0] RELAX_UNITY = OMEGA_W'(1 << OMEGA_FRAC);

  typedef logic [NDIR-1:0][DW-1:0] dist_vec_t;

  // moments stage -> equilibrium stage
  typedef struct packed {
    logic signed [RHO_W-1:0] rho;
    logic signed [J_W-1:0]   jx;
    logic signed [J_W-1:0]   jy;
    logic signed [K0_W-1:0]  k0;
    logic [C2_W-1:0]         c2;
    logic signed [WS_W-1:0]  omw;
    logic signed [WS_W-1:0]  w;
    dist_vec_t               f;
  } mom_t;

  // equilibrium stage -> relaxation stage
  typedef struct packed {
    logic [NDIR-1:0][FEQ_W-1:0] feq;
    dist_vec_t                  f;
    logic signed [WS_W-1:0]     omw;
    logic signed [WS_W-1:0]     w;
  } eq_t;

endpackage

@@ rtl/d2q5lbm_moments.sv @@
// Stage 1: density, currents, rest coefficient and effective omega.
// Depends on d2q5lbm_pkg.
module d2q5lbm_moments (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   up_ready,
  input  d2q5lbm_pkg::dist_vec_t                 in_f,
  input  logic [d2q5lbm_pkg::C2_W-1:0]           c2,
  input  logic                                   is_source,
  input  logic [d2q5lbm_pkg::DW-1:0]             src_density,
  input  logic [d2q5lbm_pkg::OMEGA_W-1:0]        relax_rate,
  output logic                                   out_valid,
  input  logic                                   down_ready,
  output d2q5lbm_pkg::mom_t                      out_data
);
  import d2q5lbm_pkg::*;

  mom_t                    mom_next;
  logic signed [RHO_W-1:0] rho_sum;
  logic [OMEGA_W-1:0]      w_eff;

  assign up_ready = !out_valid || down_ready;

  always_comb begin
    rho_sum = RHO_W'($signed(in_f[DIR_REST])) + RHO_W'($signed(in_f[DIR_EAST]))
            + RHO_W'($signed(in_f[DIR_NORTH])) + RHO_W'($signed(in_f[DIR_WEST]))
            + RHO_W'($signed(in_f[DIR_SOUTH]));
    // a source cell acts as omega = 1, so the relax stage passes feq straight out
    w_eff = is_source ? RELAX_UNITY : relax_rate;
    mom_next.f   = in_f;
    mom_next.c2  = c2;
    mom_next.rho = is_source ? RHO_W'($signed(src_density)) : rho_sum;
    mom_next.jx  = J_W'($signed(in_f[DIR_EAST])) - J_W'($signed(in_f[DIR_WEST]));
    mom_next.jy  = J_W'($signed(in_f[DIR_NORTH])) - J_W'($signed(in_f[DIR_SOUTH]));
    mom_next.k0  = K0_W'(1 << C2_FRAC) - $signed({1'b0, c2, 1'b0});
    mom_next.w   = $signed({1'b0, w_eff});
    mom_next.omw = WS_W'(1 << OMEGA_FRAC) - $signed({1'b0, w_eff});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      out_data <= mom_next;
    end
  end

  a_mom_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !down_ready |=> out_valid && $stable(out_data))
    else $error("moments stage lost or changed a stalled item");

endmodule

@@ rtl/d2q5lbm_equil.sv @@
// Stages 2 and 3: equilibrium products, then rounding of the five equilibria.
// Depends on d2q5lbm_pkg.
module d2q5lbm_equil (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               up_ready,
  input  d2q5lbm_pkg::mom_t  in_data,
  output logic               out_valid,
  input  logic               down_ready,
  output d2q5lbm_pkg::eq_t   out_data
);
  import d2q5lbm_pkg::*;

  // product stage
  logic                    prod_valid;
  logic                    prod_ready;
  logic signed [P0_W-1:0]  p0;
  logic signed [CR_W-1:0]  cr;
  logic signed [J_W-1:0]   jx;
  logic signed [J_W-1:0]   jy;
  dist_vec_t               f;
  logic signed [WS_W-1:0]  omw;
  logic signed [WS_W-1:0]  w;

  logic signed [P0_W-1:0]  t_rest;
  logic signed [EQS_W-1:0] crx;
  logic signed [EQS_W-1:0] jxs;
  logic signed [EQS_W-1:0] jys;
  logic signed [EQS_W-1:0] t_east;
  logic signed [EQS_W-1:0] t_north;
  logic signed [EQS_W-1:0] t_west;
  logic signed [EQS_W-1:0] t_south;
  eq_t                     eq_next;

  assign prod_ready = !out_valid || down_ready;
  assign up_ready   = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (up_ready) begin
        prod_valid <= in_valid;
      end
      if (prod_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      p0  <= $signed(in_data.rho) * $signed(in_data.k0);
      cr  <= $signed({1'b0, in_data.c2}) * $signed(in_data.rho);
      jx  <= in_data.jx;
      jy  <= in_data.jy;
      f   <= in_data.f;
      omw <= in_data.omw;
      w   <= in_data.w;
    end
  end

  // round half up: rest by 2^16, moving directions by 2^17 (the factor one half)
  always_comb begin
    t_rest  = p0 + P0_W'(1 << (C2_FRAC - 1));
    crx     = EQS_W'(cr) + EQS_W'(1 << C2_FRAC);
    jxs     = EQS_W'(jx) <<< C2_FRAC;
    jys     = EQS_W'(jy) <<< C2_FRAC;
    t_east  = crx + jxs;
    t_west  = crx - jxs;
    t_north = crx + jys;
    t_south = crx - jys;
    eq_next.feq[DIR_REST]  = FEQ_W'(t_rest >>> C2_FRAC);
    eq_next.feq[DIR_EAST]  = FEQ_W'(t_east >>> (C2_FRAC + 1));
    eq_next.feq[DIR_NORTH] = FEQ_W'(t_north >>> (C2_FRAC + 1));
    eq_next.feq[DIR_WEST]  = FEQ_W'(t_west >>> (C2_FRAC + 1));
    eq_next.feq[DIR_SOUTH] = FEQ_W'(t_south >>> (C2_FRAC + 1));
    eq_next.f   = f;
    eq_next.omw = omw;
    eq_next.w   = w;
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      out_data <= eq_next;
    end
  end

endmodule

@@ rtl/d2q5lbm_relax.sv @@
// Stages 4 and 5: relaxation products, then rounding and saturation to 32 bits.
// Depends on d2q5lbm_pkg.
module d2q5lbm_relax (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    up_ready,
  input  d2q5lbm_pkg::eq_t        in_data,
  output logic                    out_valid,
  input  logic                    down_ready,
  output d2q5lbm_pkg::dist_vec_t  out_f
);
  import d2q5lbm_pkg::*;

  localparam logic signed [SH_W-1:0] SAT_MAX = {{(SH_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_MIN = {{(SH_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic                    prod_valid;
  logic                    prod_ready;
  logic signed [RA_W-1:0]  ra [NDIR];
  logic signed [RB_W-1:0]  rb [NDIR];
  logic signed [ACC_W-1:0] acc [NDIR];
  logic signed [SH_W-1:0]  sh [NDIR];
  dist_vec_t               f_next;

  assign prod_ready = !out_valid || down_ready;
  assign up_ready   = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (up_ready) begin
        prod_valid <= in_valid;
      end
      if (prod_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      for (int i = 0; i < NDIR; i++) begin
        ra[i] <= $signed(in_data.omw) * $signed(in_data.f[i]);
        rb[i] <= $signed(in_data.w) * $signed(in_data.feq[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NDIR; i++) begin
      acc[i] = ACC_W'(ra[i]) + ACC_W'(rb[i]) + ACC_W'(1 << (OMEGA_FRAC - 1));
      sh[i]  = SH_W'(acc[i] >>> OMEGA_FRAC);
      if (sh[i] > SAT_MAX) begin
        f_next[i] = DW'(SAT_MAX);
      end else if (sh[i] < SAT_MIN) begin
        f_next[i] = DW'(SAT_MIN);
      end else begin
        f_next[i] = DW'(sh[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      out_f <= f_next;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !down_ready |=> out_valid && $stable(out_f))
    else $error("stalled result lost or changed");

  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    prod_valid && !prod_ready |=> prod_valid)
    else $error("relaxation product dropped under stall");

endmodule

@@ rtl/d2q5_lattice_boltzmann_collision_unit.sv @@
// D2Q5 lattice Boltzmann wave collision, one cell per transfer.
// Depends on d2q5lbm_pkg, d2q5lbm_moments, d2q5lbm_equil, d2q5lbm_relax.
//
// Input channel (in_valid / in_stall) carries one cell: five Q16.16
// distributions, c^2 (Q0.16), a source flag and the source density.
// Output channel (out_valid / out_stall) carries the five post-collision
// distributions, rounded half up and saturated to 32 bits.
// relax_rate (omega, Q2.16) is written by relax_rate_wr_en / _wr_data;
// change it only while no cell is in flight.
//
// Five register stages: moments, equilibrium products, equilibria,
// relaxation products, output register. Throughput is one cell per
// clock while the receiver does not stall; the multipliers are fully
// pipelined. Each stage holds its item while the next is full, so a
// receiver stall fills the pipe and then stalls the sender; no
// transfer is lost or repeated. Reset (rst, synchronous) empties the
// pipeline and sets omega to 2.0.
module d2q5_lattice_boltzmann_collision_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                relax_rate_wr_en,
  input  logic [d2q5lbm_pkg::OMEGA_W-1:0]     relax_rate_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [d2q5lbm_pkg::DW-1:0]          dist_rest,
  input  logic [d2q5lbm_pkg::DW-1:0]          dist_east,
  input  logic [d2q5lbm_pkg::DW-1:0]          dist_north,
  input  logic [d2q5lbm_pkg::DW-1:0]          dist_west,
  input  logic [d2q5lbm_pkg::DW-1:0]          dist_south,
  input  logic [d2q5lbm_pkg::C2_W-1:0]        sound_speed_sq,
  input  logic                                is_source,
  input  logic [d2q5lbm_pkg::DW-1:0]          source_density,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [d2q5lbm_pkg::DW-1:0]          new_rest,
  output logic [d2q5lbm_pkg::DW-1:0]          new_east,
  output logic [d2q5lbm_pkg::DW-1:0]          new_north,
  output logic [d2q5lbm_pkg::DW-1:0]          new_west,
  output logic [d2q5lbm_pkg::DW-1:0]          new_south
);
  import d2q5lbm_pkg::*;

  logic [OMEGA_W-1:0] relax_rate;
  dist_vec_t          in_f;
  dist_vec_t          out_f;
  logic               mom_ready;
  logic               mom_valid;
  mom_t               mom_data;
  logic               eq_ready;
  logic               eq_valid;
  eq_t                eq_data;
  logic               rlx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= RELAX_RESET;
    end else if (relax_rate_wr_en) begin
      relax_rate <= relax_rate_wr_data;
    end
  end

  assign in_f[DIR_REST]  = dist_rest;
  assign in_f[DIR_EAST]  = dist_east;
  assign in_f[DIR_NORTH] = dist_north;
  assign in_f[DIR_WEST]  = dist_west;
  assign in_f[DIR_SOUTH] = dist_south;

  assign in_stall = !mom_ready;

  d2q5lbm_moments u_moments (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .up_ready    (mom_ready),
    .in_f        (in_f),
    .c2          (sound_speed_sq),
    .is_source   (is_source),
    .src_density (source_density),
    .relax_rate  (relax_rate),
    .out_valid   (mom_valid),
    .down_ready  (eq_ready),
    .out_data    (mom_data)
  );

  d2q5lbm_equil u_equil (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mom_valid),
    .up_ready   (eq_ready),
    .in_data    (mom_data),
    .out_valid  (eq_valid),
    .down_ready (rlx_ready),
    .out_data   (eq_data)
  );

  d2q5lbm_relax u_relax (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (eq_valid),
    .up_ready   (rlx_ready),
    .in_data    (eq_data),
    .out_valid  (out_valid),
    .down_ready (!out_stall),
    .out_f      (out_f)
  );

  assign new_rest  = out_f[DIR_REST];
  assign new_east  = out_f[DIR_EAST];
  assign new_north = out_f[DIR_NORTH];
  assign new_west  = out_f[DIR_WEST];
  assign new_south = out_f[DIR_SOUTH];

  // the sender only sees back-pressure once every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_omega_reset: assert property (@(posedge clk)
    rst |=> relax_rate == RELAX_RESET)
    else $error("omega not restored by reset");

endmodule

@@ tb/d2q5_lattice_boltzmann_collision_unit_tb.sv @@
// Self-checking testbench for the D2Q5 collision unit: directed table, then random cells
// over several relaxation rates; results held to typed rows or a cycle-free predictor.
// Depends on d2q5lbm_pkg and d2q5_lattice_boltzmann_collision_unit.
module d2q5_lattice_boltzmann_collision_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import d2q5lbm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_CELLS = 232;

  typedef struct packed {
    dist_vec_t         f;
    logic [C2_W-1:0]   c2;
    logic              src;
    logic [DW-1:0]     sdens;
  } cell_t;

  typedef struct {
    cell_t     c;
    bit        typed;
    dist_vec_t res;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                relax_rate_wr_en = 1'b0;
  logic [OMEGA_W-1:0]  relax_rate_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [DW-1:0]       dist_rest = '0;
  logic [DW-1:0]       dist_east = '0;
  logic [DW-1:0]       dist_north = '0;
  logic [DW-1:0]       dist_west = '0;
  logic [DW-1:0]       dist_south = '0;
  logic [C2_W-1:0]     sound_speed_sq = '0;
  logic                is_source = 1'b0;
  logic [DW-1:0]       source_density = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DW-1:0]       new_rest;
  logic [DW-1:0]       new_east;
  logic [DW-1:0]       new_north;
  logic [DW-1:0]       new_west;
  logic [DW-1:0]       new_south;

  dist_vec_t          pending_post_collision[$];
  row_t               directed_rows[$];
  logic [OMEGA_W-1:0] omega_model = RELAX_RESET;
  int                 mismatches = 0;
  int                 cycle_count = 0;
  int                 sender_mode = 0;
  int                 stall_mode = 0;
  int                 stall_run = 0;
  int                 stall_pick;

  d2q5_lattice_boltzmann_collision_unit u_top (
    .clk                (clk),
    .rst                (rst),
    .relax_rate_wr_en   (relax_rate_wr_en),
    .relax_rate_wr_data (relax_rate_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .dist_rest          (dist_rest),
    .dist_east          (dist_east),
    .dist_north         (dist_north),
    .dist_west          (dist_west),
    .dist_south         (dist_south),
    .sound_speed_sq     (sound_speed_sq),
    .is_source          (is_source),
    .source_density     (source_density),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .new_rest           (new_rest),
    .new_east           (new_east),
    .new_north          (new_north),
    .new_west           (new_west),
    .new_south          (new_south)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // round half up: add half an lsb, then floor
  function automatic longint round_half_up(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [DW-1:0] clamp32(longint x);
    if (x > 64'sd2147483647)
      return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648)
      return 32'h8000_0000;
    return x[DW-1:0];
  endfunction

  function automatic dist_vec_t collide_cell(cell_t c, logic [OMEGA_W-1:0] omega);
    longint    f[NDIR];
    longint    feq[NDIR];
    longint    dotj[NDIR];
    longint    rho, jx, jy, c2v, unit, w, acc;
    dist_vec_t res;
    for (int i = 0; i < NDIR; i++)
      f[i] = longint'($signed(c.f[i]));
    c2v  = longint'(c.c2);
    unit = longint'(1) <<< C2_FRAC;
    jx   = f[DIR_EAST] - f[DIR_WEST];
    jy   = f[DIR_NORTH] - f[DIR_SOUTH];
    rho  = c.src ? longint'($signed(c.sdens))
                 : f[DIR_REST] + f[DIR_EAST] + f[DIR_NORTH] + f[DIR_WEST] + f[DIR_SOUTH];
    dotj[DIR_REST]  = 0;
    dotj[DIR_EAST]  = jx;
    dotj[DIR_NORTH] = jy;
    dotj[DIR_WEST]  = -jx;
    dotj[DIR_SOUTH] = -jy;
    feq[DIR_REST] = round_half_up(rho * (unit - 2 * c2v), C2_FRAC);
    for (int i = DIR_EAST; i < NDIR; i++)
      feq[i] = round_half_up(c2v * rho + dotj[i] * unit, C2_FRAC + 1);
    w = longint'(omega);
    for (int i = 0; i < NDIR; i++) begin
      if (c.src) begin
        res[i] = clamp32(feq[i]);
      end else begin
        acc    = ((longint'(1) <<< OMEGA_FRAC) - w) * f[i] + w * feq[i];
        res[i] = clamp32(round_half_up(acc, OMEGA_FRAC));
      end
    end
    return res;
  endfunction

  function automatic dist_vec_t five(logic [DW-1:0] r, logic [DW-1:0] e, logic [DW-1:0] n,
                                     logic [DW-1:0] w, logic [DW-1:0] s);
    dist_vec_t v;
    v[DIR_REST]  = r;
    v[DIR_EAST]  = e;
    v[DIR_NORTH] = n;
    v[DIR_WEST]  = w;
    v[DIR_SOUTH] = s;
    return v;
  endfunction

  function automatic cell_t mk_cell(dist_vec_t f, logic [C2_W-1:0] c2, logic src,
                                    logic [DW-1:0] sdens);
    cell_t c;
    c.f     = f;
    c.c2    = c2;
    c.src   = src;
    c.sdens = sdens;
    return c;
  endfunction

  // full-range words and small Q16.16 magnitudes, some extremes
  function automatic logic [DW-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      return $urandom;
    if (pick < 8)
      return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    int    pick;
    for (int i = 0; i < NDIR; i++)
      c.f[i] = rand_word();
    pick = $urandom_range(0, 9);
    c.c2  = (pick < 8) ? C2_W'($urandom) : (pick == 8) ? '0 : '1;
    c.src = ($urandom_range(0, 3) == 0);
    c.sdens = rand_word();
    return c;
  endfunction

  // mostly short gaps, a few long ones; none in mode 0
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0)
      return 0;
    r = $urandom_range(0, 99);
    if (r < ((mode == 1) ? 70 : 40))
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (stall_mode == 0) begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(5, 30);
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < ((stall_mode == 1) ? 20 : 50)) begin
        out_stall <= 1'b1;
        stall_run <= ($urandom_range(0, 99) < 92) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 40);
      end else begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 5);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_post_collision.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer rest=%h east=%h north=%h west=%h south=%h",
                 $time, new_rest, new_east, new_north, new_west, new_south);
      end else begin
        dist_vec_t want;
        want = pending_post_collision.pop_front();
        if (want[DIR_REST] !== new_rest) begin
          mismatches++;
          $display("%0t: new_rest expected %h actual %h", $time, want[DIR_REST], new_rest);
        end
        if (want[DIR_EAST] !== new_east) begin
          mismatches++;
          $display("%0t: new_east expected %h actual %h", $time, want[DIR_EAST], new_east);
        end
        if (want[DIR_NORTH] !== new_north) begin
          mismatches++;
          $display("%0t: new_north expected %h actual %h", $time, want[DIR_NORTH], new_north);
        end
        if (want[DIR_WEST] !== new_west) begin
          mismatches++;
          $display("%0t: new_west expected %h actual %h", $time, want[DIR_WEST], new_west);
        end
        if (want[DIR_SOUTH] !== new_south) begin
          mismatches++;
          $display("%0t: new_south expected %h actual %h", $time, want[DIR_SOUTH], new_south);
        end
      end
    end
  end

  // called at a clock edge; returns at the edge of the transfer
  task automatic send_cell(cell_t c, int gap, bit typed, dist_vec_t typed_res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    dist_rest      <= c.f[DIR_REST];
    dist_east      <= c.f[DIR_EAST];
    dist_north     <= c.f[DIR_NORTH];
    dist_west      <= c.f[DIR_WEST];
    dist_south     <= c.f[DIR_SOUTH];
    sound_speed_sq <= c.c2;
    is_source      <= c.src;
    source_density <= c.sdens;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_post_collision.push_back(typed ? typed_res : collide_cell(c, omega_model));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_post_collision.size() != 0) @(posedge clk);
  endtask

  task automatic write_relax(logic [OMEGA_W-1:0] v);
    drain_results();
    relax_rate_wr_en   <= 1'b1;
    relax_rate_wr_data <= v;
    @(posedge clk);
    relax_rate_wr_en <= 1'b0;
    omega_model = v;
  endtask

  initial begin
    logic [OMEGA_W-1:0] phase_omega[PHASES];
    // typed rows are read straight off the equations with omega = 2 and, but for the last, c2 = 0
    directed_rows.push_back(row_t'{mk_cell(five(0, 0, 0, 0, 0), 16'h0000, 1'b0, 0),
                                   1'b1, five(0, 0, 0, 0, 0)});
    directed_rows.push_back(row_t'{mk_cell(five(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                32'h7FFF_FFFF, 32'h7FFF_FFFF),
                                           16'h0000, 1'b0, 0), 1'b1,
                                   five(32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0001,
                                        32'h8000_0001, 32'h8000_0001)});
    directed_rows.push_back(row_t'{mk_cell(five(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                                32'h8000_0000, 32'h8000_0000),
                                           16'h0000, 1'b0, 0), 1'b1,
                                   five(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF)});
    directed_rows.push_back(row_t'{mk_cell(five(0, 0, 0, 0, 0), 16'h0000, 1'b1, 32'h7FFF_FFFF),
                                   1'b1, five(32'h7FFF_FFFF, 0, 0, 0, 0)});
    directed_rows.push_back(row_t'{mk_cell(five(0, 0, 0, 0, 0), 16'h0000, 1'b1, 32'h8000_0000),
                                   1'b1, five(32'h8000_0000, 0, 0, 0, 0)});
    directed_rows.push_back(row_t'{mk_cell(five(0, 0, 0, 0, 0), 16'hFFFF, 1'b1, 0),
                                   1'b1, five(0, 0, 0, 0, 0)});
    // rounding on half an lsb, both signs
    directed_rows.push_back(row_t'{mk_cell(five(0, 1, 0, 0, 0), 16'h0000, 1'b0, 0), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(0, 0, 0, 1, 0), 16'h0000, 1'b0, 0), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(0, 0, '1, 0, 1), 16'h0001, 1'b0, 0), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(1, 0, 0, 0, 0), 16'h8000, 1'b1, 32'hFFFF_FFFF),
                                   1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                                32'h0001_0000, 32'h0001_0000),
                                           16'hFFFF, 1'b0, 0), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(32'h0003_0000, 32'h0002_8000, 32'hFFFF_4000,
                                                32'h0000_C000, 32'h0001_0001),
                                           16'h8000, 1'b0, 0), 1'b0, '0});
    // source cell: currents still come from the distributions
    directed_rows.push_back(row_t'{mk_cell(five(32'h0005_0000, 32'h0004_0000, 32'hFFFE_0000,
                                                32'h0001_0000, 32'h0003_0000),
                                           16'h4000, 1'b1, 32'h0001_0000), 1'b0, '0});
    // normal cell ignores the imposed density
    directed_rows.push_back(row_t'{mk_cell(five(32'h0000_8000, 32'h0001_0000, 32'h0000_4000,
                                                32'hFFFF_8000, 32'h0000_2000),
                                           16'h2000, 1'b0, 32'h7FFF_FFFF), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                                32'h5555_5555, 32'hAAAA_AAAA),
                                           16'hAAAA, 1'b0, 32'h5555_5555), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                                32'hAAAA_AAAA, 32'h5555_5555),
                                           16'h5555, 1'b1, 32'hAAAA_AAAA), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five('1, '1, '1, '1, '1), 16'hFFFF, 1'b1, '1),
                                   1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                                32'h8000_0000, 32'h7FFF_FFFF),
                                           16'hFFFF, 1'b0, 0), 1'b0, '0});
    directed_rows.push_back(row_t'{mk_cell(five(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                32'h8000_0000, 32'h8000_0000),
                                           16'h0001, 1'b1, 32'h7FFF_FFFF), 1'b0, '0});

    // rate extremes among the settings; the last one stays random
    phase_omega = '{RELAX_UNITY, 18'd0, 18'd1, 18'h3FFFF, RELAX_RESET, 18'h0C000,
                    18'h08000, 18'd0};
    phase_omega[PHASES-1] = OMEGA_W'($urandom_range(0, 18'h3FFFF));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    sender_mode = 1;
    stall_mode  = 1;
    foreach (directed_rows[i])
      send_cell(directed_rows[i].c, pick_gap(sender_mode), directed_rows[i].typed,
                directed_rows[i].res);

    for (int p = 0; p < PHASES; p++) begin
      write_relax(phase_omega[p]);
      sender_mode = (p == 0) ? 0 : $urandom_range(0, 2);
      stall_mode  = (p == 0) ? 0 : (p == 3) ? 2 : $urandom_range(0, 2);
      for (int k = 0; k < PHASE_CELLS; k++) begin
        // sender holds off once until the pipe has fully emptied
        if (p == 2 && k == 60)
          drain_results();
        send_cell(rand_cell(), pick_gap(sender_mode), 1'b0, '0);
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
